// ===== rtl/fatcca_pkg.sv =====
// Shared types and constants for the cluster chain allocator.
`default_nettype none

package fatcca_pkg;

    localparam int CLUSTER_CAPACITY = 256;
    localparam int DIR_ENTRIES      = 16;
    localparam int NAME_W           = 64;
    localparam int CL_IDX_W         = $clog2(CLUSTER_CAPACITY);
    localparam int LINK_W           = CL_IDX_W + 1;
    localparam int DIR_IDX_W        = $clog2(DIR_ENTRIES);
    localparam int CNT_W            = DIR_IDX_W + 1;

    localparam logic [LINK_W-1:0] LINK_FREE = LINK_W'(CLUSTER_CAPACITY);
    localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(CLUSTER_CAPACITY + 1);

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_DIR_FULL  = 3'd2;
    localparam logic [2:0] ST_NO_SPACE  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic FUNC_ALLOC  = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    typedef struct packed {
        logic                en;
        logic [CL_IDX_W-1:0] addr;
        logic [LINK_W-1:0]   data;
    } link_wr_t;

endpackage

`default_nettype wire

// ===== rtl/fatcca_link_table.sv =====
// Cluster link table memory with per-entry valid bits that read as free after reset.
`default_nettype none

module fatcca_link_table
    import fatcca_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [CL_IDX_W-1:0] rd_addr,
    output logic      [LINK_W-1:0]   rd_data,
    input  wire link_wr_t            wr
);

    logic [LINK_W-1:0]           mem [CLUSTER_CAPACITY];
    logic [CLUSTER_CAPACITY-1:0] valid_reg;
    logic [LINK_W-1:0]           rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : LINK_FREE;
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/fat_cluster_chain_allocator_core.sv =====
// Top level of the cluster chain allocator: directory, request sequencer and result register.
// One request at a time; in_ready is high only while idle. The result loads once the output register is empty or taken.
// Name lookup reads and compares each directory entry in turn.
// Allocate adds two link table scans, each over at most min(cluster_count, 256) clusters.
// Delete adds a read and check of each chain link, then moves the last directory entry into the freed slot.
// Reset clears the directory count, the result valid flag and the link table valid bits at once.
`default_nettype none

module fat_cluster_chain_allocator_core
    import fatcca_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [8:0]        cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [NAME_W-1:0] file_name,
    input  wire logic [8:0]        cluster_request,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [2:0]        status,
    output logic      [7:0]        first_cluster,
    output logic      [8:0]        cluster_total
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LOOK_RD   = 4'd1;
    localparam logic [3:0] S_LOOK_CMP  = 4'd2;
    localparam logic [3:0] S_CNT       = 4'd3;
    localparam logic [3:0] S_ALLOC     = 4'd4;
    localparam logic [3:0] S_ALLOC_END = 4'd5;
    localparam logic [3:0] S_WALK_RD   = 4'd6;
    localparam logic [3:0] S_WALK_CHK  = 4'd7;
    localparam logic [3:0] S_DEL_RD    = 4'd8;
    localparam logic [3:0] S_DEL_WR    = 4'd9;
    localparam logic [3:0] S_FIN       = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    entry_count_reg, entry_count_next;
    logic [8:0]          cluster_count_reg, cluster_count_next;
    logic                out_valid_reg, out_valid_next;

    logic                func_reg, func_next;
    logic [NAME_W-1:0]   key_reg, key_next;
    logic [8:0]          need_reg, need_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [8:0]          scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [CL_IDX_W-1:0] chk_addr_reg, chk_addr_next;
    logic [8:0]          free_reg, free_next;
    logic [8:0]          taken_reg, taken_next;
    logic                have_prev_reg, have_prev_next;
    logic [CL_IDX_W-1:0] prev_reg, prev_next;
    logic [CL_IDX_W-1:0] first_reg, first_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [8:0]          freed_reg, freed_next;
    logic [2:0]          res_status_reg, res_status_next;
    logic [7:0]          res_first_reg, res_first_next;
    logic [8:0]          res_total_reg, res_total_next;
    logic [2:0]          out_status_reg, out_status_next;
    logic [7:0]          out_first_reg, out_first_next;
    logic [8:0]          out_total_reg, out_total_next;

    logic [NAME_W-1:0]   dir_name_mem  [DIR_ENTRIES];
    logic [CL_IDX_W-1:0] dir_start_mem [DIR_ENTRIES];
    logic [8:0]          dir_size_mem  [DIR_ENTRIES];
    logic [NAME_W-1:0]   dir_rd_name_reg;
    logic [CL_IDX_W-1:0] dir_rd_start_reg;
    logic [8:0]          dir_rd_size_reg;
    logic [DIR_IDX_W-1:0] dir_raddr;
    logic                dir_we;
    logic [DIR_IDX_W-1:0] dir_waddr;
    logic [NAME_W-1:0]   dir_wname;
    logic [CL_IDX_W-1:0] dir_wstart;
    logic [8:0]          dir_wsize;

    logic [CL_IDX_W-1:0] link_rd_addr;
    logic [LINK_W-1:0]   link_rd_data;
    link_wr_t            link_wr;

    logic [8:0]          limit;
    logic [CNT_W-1:0]    last_idx;
    logic                load_out;

    fatcca_link_table u_link_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .wr      (link_wr)
    );

    assign limit    = (cluster_count_reg > 9'(CLUSTER_CAPACITY)) ? 9'(CLUSTER_CAPACITY)
                                                                 : cluster_count_reg;
    assign last_idx = entry_count_reg - CNT_W'(1);

    always_comb
    begin
        state_next         = state_reg;
        entry_count_next   = entry_count_reg;
        cluster_count_next = cfg_we ? cfg_wdata : cluster_count_reg;
        func_next          = func_reg;
        key_next           = key_reg;
        need_next          = need_reg;
        idx_next           = idx_reg;
        scan_next          = scan_reg;
        pend_next          = pend_reg;
        chk_addr_next      = chk_addr_reg;
        free_next          = free_reg;
        taken_next         = taken_reg;
        have_prev_next     = have_prev_reg;
        prev_next          = prev_reg;
        first_next         = first_reg;
        cur_next           = cur_reg;
        freed_next         = freed_reg;
        res_status_next    = res_status_reg;
        res_first_next     = res_first_reg;
        res_total_next     = res_total_reg;
        load_out           = 1'b0;
        link_rd_addr       = scan_reg[CL_IDX_W-1:0];
        link_wr            = '0;
        dir_raddr          = idx_reg[DIR_IDX_W-1:0];
        dir_we             = 1'b0;
        dir_waddr          = entry_count_reg[DIR_IDX_W-1:0];
        dir_wname          = key_reg;
        dir_wstart         = first_reg;
        dir_wsize          = need_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    key_next   = file_name;
                    need_next  = cluster_request;
                    idx_next   = '0;
                    state_next = S_LOOK_RD;
                end
            end
            S_LOOK_RD:
            begin
                if (idx_reg >= entry_count_reg)
                begin
                    res_first_next = '0;
                    res_total_next = '0;
                    if (func_reg == FUNC_DELETE)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_FIN;
                    end
                    else if (entry_count_reg == CNT_W'(DIR_ENTRIES))
                    begin
                        res_status_next = ST_DIR_FULL;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        scan_next  = '0;
                        pend_next  = 1'b0;
                        free_next  = '0;
                        state_next = S_CNT;
                    end
                end
                else
                begin
                    state_next = S_LOOK_CMP;
                end
            end
            S_LOOK_CMP:
            begin
                if (dir_rd_name_reg == key_reg)
                begin
                    if (func_reg == FUNC_DELETE)
                    begin
                        first_next = dir_rd_start_reg;
                        cur_next   = {1'b0, dir_rd_start_reg};
                        freed_next = '0;
                        state_next = S_WALK_RD;
                    end
                    else
                    begin
                        res_status_next = ST_DUPLICATE;
                        res_first_next  = '0;
                        res_total_next  = '0;
                        state_next      = S_FIN;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_LOOK_RD;
                end
            end
            S_CNT:
            begin
                if (pend_reg && link_rd_data == LINK_FREE)
                begin
                    free_next = free_reg + 9'd1;
                end
                if (scan_reg < limit)
                begin
                    pend_next     = 1'b1;
                    chk_addr_next = scan_reg[CL_IDX_W-1:0];
                    scan_next     = scan_reg + 9'd1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (need_reg == '0 || free_reg < need_reg)
                        begin
                            res_status_next = ST_NO_SPACE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            scan_next      = '0;
                            taken_next     = '0;
                            have_prev_next = 1'b0;
                            state_next     = S_ALLOC;
                        end
                    end
                end
            end
            S_ALLOC:
            begin
                if (taken_reg == need_reg)
                begin
                    state_next = S_ALLOC_END;
                end
                else
                begin
                    if (pend_reg && link_rd_data == LINK_FREE)
                    begin
                        if (have_prev_reg)
                        begin
                            link_wr.en   = 1'b1;
                            link_wr.addr = prev_reg;
                            link_wr.data = {1'b0, chk_addr_reg};
                        end
                        else
                        begin
                            first_next = chk_addr_reg;
                        end
                        prev_next      = chk_addr_reg;
                        have_prev_next = 1'b1;
                        taken_next     = taken_reg + 9'd1;
                    end
                    if (scan_reg < limit)
                    begin
                        pend_next     = 1'b1;
                        chk_addr_next = scan_reg[CL_IDX_W-1:0];
                        scan_next     = scan_reg + 9'd1;
                    end
                    else
                    begin
                        pend_next = 1'b0;
                    end
                end
            end
            S_ALLOC_END:
            begin
                link_wr.en       = 1'b1;
                link_wr.addr     = prev_reg;
                link_wr.data     = LINK_END;
                dir_we           = 1'b1;
                entry_count_next = entry_count_reg + CNT_W'(1);
                res_status_next  = ST_DONE;
                res_first_next   = first_reg;
                res_total_next   = taken_reg;
                state_next       = S_FIN;
            end
            S_WALK_RD:
            begin
                link_rd_addr = cur_reg[CL_IDX_W-1:0];
                state_next   = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (link_rd_data == LINK_FREE)
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    link_wr.en   = 1'b1;
                    link_wr.addr = cur_reg[CL_IDX_W-1:0];
                    link_wr.data = LINK_FREE;
                    freed_next   = freed_reg + 9'd1;
                    cur_next     = link_rd_data;
                    if (link_rd_data[LINK_W-1]
                        || freed_reg + 9'd1 == 9'(CLUSTER_CAPACITY))
                    begin
                        state_next = S_DEL_RD;
                    end
                    else
                    begin
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_DEL_RD:
            begin
                dir_raddr  = last_idx[DIR_IDX_W-1:0];
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                dir_we           = 1'b1;
                dir_waddr        = idx_reg[DIR_IDX_W-1:0];
                dir_wname        = dir_rd_name_reg;
                dir_wstart       = dir_rd_start_reg;
                dir_wsize        = dir_rd_size_reg;
                entry_count_next = last_idx;
                res_status_next  = ST_DONE;
                res_first_next   = first_reg;
                res_total_next   = freed_reg;
                state_next       = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next  = load_out ? 1'b1 : (out_valid_reg && !out_ready);
        out_status_next = load_out ? res_status_reg : out_status_reg;
        out_first_next  = load_out ? res_first_reg : out_first_reg;
        out_total_next  = load_out ? res_total_reg : out_total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            entry_count_reg   <= '0;
            cluster_count_reg <= 9'(CLUSTER_CAPACITY);
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            entry_count_reg   <= entry_count_next;
            cluster_count_reg <= cluster_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        need_reg       <= need_next;
        idx_reg        <= idx_next;
        scan_reg       <= scan_next;
        pend_reg       <= pend_next;
        chk_addr_reg   <= chk_addr_next;
        free_reg       <= free_next;
        taken_reg      <= taken_next;
        have_prev_reg  <= have_prev_next;
        prev_reg       <= prev_next;
        first_reg      <= first_next;
        cur_reg        <= cur_next;
        freed_reg      <= freed_next;
        res_status_reg <= res_status_next;
        res_first_reg  <= res_first_next;
        res_total_reg  <= res_total_next;
        out_status_reg <= out_status_next;
        out_first_reg  <= out_first_next;
        out_total_reg  <= out_total_next;
    end

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_name_mem[dir_waddr]  <= dir_wname;
            dir_start_mem[dir_waddr] <= dir_wstart;
            dir_size_mem[dir_waddr]  <= dir_wsize;
        end
        dir_rd_name_reg  <= dir_name_mem[dir_raddr];
        dir_rd_start_reg <= dir_start_mem[dir_raddr];
        dir_rd_size_reg  <= dir_size_mem[dir_raddr];
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign first_cluster = out_first_reg;
    assign cluster_total = out_total_reg;

endmodule

`default_nettype wire

// ===== rtl/fatcca_checker.sv =====
// Port-level assertions for the cluster chain allocator, bound to the top level.
`default_nettype none

module fatcca_checker
    import fatcca_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] status,
    input wire logic [7:0] first_cluster,
    input wire logic [8:0] cluster_total
);

    // A beat that stalls on the result side keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(first_cluster) && $stable(cluster_total))
        else $error("result beat changed while stalled");

    // Failed requests report no chain.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> first_cluster == 8'd0 && cluster_total == 9'd0)
        else $error("failed request reports a chain");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_DONE || status == ST_DUPLICATE || status == ST_DIR_FULL
            || status == ST_NO_SPACE || status == ST_NOT_FOUND)
        else $error("status code out of range");

    // A request holds the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a request beat");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cluster_total <= 9'(CLUSTER_CAPACITY))
        else $error("cluster total above capacity");

endmodule

bind fat_cluster_chain_allocator_core fatcca_checker u_fatcca_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .first_cluster (first_cluster),
    .cluster_total (cluster_total)
);

`default_nettype wire
